/* rtl/esc_pkg.sv */
// esc_pkg: shared types, constants and microcode for the epoch-to-calendar core
// no dependencies; used by esc_div.sv and epoch_seconds_to_calendar_core.sv

package esc_pkg;

    localparam int unsigned PC_BITS   = 3;
    localparam int unsigned YEAR_BITS = 13;
    localparam int unsigned YCYC_BITS = 9;    // year within 400-year cycle
    localparam int unsigned STEP_BITS = 64;   // step constants, covers the widest input

    localparam logic [YEAR_BITS-1:0] YEAR_BASE     = 13'd1970;
    localparam logic [YEAR_BITS-1:0] YEARS_PER_400 = 13'd400;
    localparam logic [YCYC_BITS-1:0] YCYC_BASE     = 9'd370;   // 1970 mod 400
    localparam logic [YCYC_BITS-1:0] YCYC_LAST     = 9'd399;
    localparam logic [3:0]           MONTH_LAST    = 4'd11;    // december, counted from 0
    localparam logic [2:0]           WDAY_BASE     = 3'd4;     // epoch day was a thursday

    // seconds removed by one step of each loop
    localparam logic [STEP_BITS-1:0] SECS_PER_MIN       = 64'd60;
    localparam logic [STEP_BITS-1:0] SECS_PER_HOUR      = 64'd3600;
    localparam logic [STEP_BITS-1:0] SECS_PER_DAY       = 64'd86400;
    localparam logic [STEP_BITS-1:0] SECS_PER_28_DAYS   = 64'd2419200;
    localparam logic [STEP_BITS-1:0] SECS_PER_29_DAYS   = 64'd2505600;
    localparam logic [STEP_BITS-1:0] SECS_PER_30_DAYS   = 64'd2592000;
    localparam logic [STEP_BITS-1:0] SECS_PER_31_DAYS   = 64'd2678400;
    localparam logic [STEP_BITS-1:0] SECS_PER_YEAR      = 64'd31536000;
    localparam logic [STEP_BITS-1:0] SECS_PER_LEAP_YEAR = 64'd31622400;
    localparam logic [STEP_BITS-1:0] SECS_PER_400Y      = 64'd12622780800;

    // sequencer state
    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    // datapath operation of one microcode step
    typedef enum logic [2:0]
    {
        OP_SPAN,
        OP_YEAR,
        OP_MONTH,
        OP_DAY,
        OP_HOUR,
        OP_MIN,
        OP_DONE
    } op_t;

    // jump condition: taken -> go to target, else fall through
    typedef enum logic [1:0]
    {
        CN_NEVER,
        CN_FITS,
        CN_MONTH_FITS
    } cond_t;

    typedef struct packed
    {
        op_t                op;
        cond_t              cond;
        logic [PC_BITS-1:0] target;
    } uword_t;

    localparam logic [PC_BITS-1:0] PC_START = 3'd0;
    localparam logic [PC_BITS-1:0] PC_SPAN  = 3'd0;
    localparam logic [PC_BITS-1:0] PC_YEAR  = 3'd1;
    localparam logic [PC_BITS-1:0] PC_MONTH = 3'd2;
    localparam logic [PC_BITS-1:0] PC_DAY   = 3'd3;
    localparam logic [PC_BITS-1:0] PC_HOUR  = 3'd4;
    localparam logic [PC_BITS-1:0] PC_MIN   = 3'd5;
    localparam logic [PC_BITS-1:0] PC_DONE  = 3'd6;

    // microcode rom: each loop step repeats while its unit still fits; the month step also stops at december
    function automatic uword_t ucode(input logic [PC_BITS-1:0] pc);
        uword_t w;
        unique case (pc)
            PC_SPAN:  w = '{OP_SPAN,  CN_FITS,       PC_SPAN};
            PC_YEAR:  w = '{OP_YEAR,  CN_FITS,       PC_YEAR};
            PC_MONTH: w = '{OP_MONTH, CN_MONTH_FITS, PC_MONTH};
            PC_DAY:   w = '{OP_DAY,   CN_FITS,       PC_DAY};
            PC_HOUR:  w = '{OP_HOUR,  CN_FITS,       PC_HOUR};
            PC_MIN:   w = '{OP_MIN,   CN_FITS,       PC_MIN};
            PC_DONE:  w = '{OP_DONE,  CN_NEVER,      PC_START};
            default:  w = '{OP_DONE,  CN_NEVER,      PC_START};
        endcase
        return w;
    endfunction

    // leap test on year mod 400
    function automatic logic is_leap(input logic [YCYC_BITS-1:0] ycyc);
        return (ycyc[1:0] == 2'd0) && (ycyc != 9'd100) && (ycyc != 9'd200)
            && (ycyc != 9'd300);
    endfunction

    // days in month, month counted from 0
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        case (month)
            4'd1:                      n = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [STEP_BITS-1:0] month_secs(input logic [4:0] mdays);
        logic [STEP_BITS-1:0] d;
        case (mdays)
            5'd28:   d = SECS_PER_28_DAYS;
            5'd29:   d = SECS_PER_29_DAYS;
            5'd30:   d = SECS_PER_30_DAYS;
            default: d = SECS_PER_31_DAYS;
        endcase
        return d;
    endfunction

    // seconds taken by one step of the current operation
    function automatic logic [STEP_BITS-1:0] step_secs(input op_t op, input logic leap,
                                                        input logic [4:0] mdays);
        logic [STEP_BITS-1:0] d;
        unique case (op)
            OP_SPAN:  d = SECS_PER_400Y;
            OP_YEAR:  d = leap ? SECS_PER_LEAP_YEAR : SECS_PER_YEAR;
            OP_MONTH: d = month_secs(mdays);
            OP_DAY:   d = SECS_PER_DAY;
            OP_HOUR:  d = SECS_PER_HOUR;
            default:  d = SECS_PER_MIN;
        endcase
        return d;
    endfunction

endpackage

/* rtl/esc_div.sv */
// esc_div: compare-and-subtract step of the repeated-subtraction breakdown
// depends on esc_pkg (STEP_BITS)

module esc_div #(
    parameter int unsigned SECONDS_BITS = 36
) (
    input  logic [SECONDS_BITS-1:0]         secs,
    input  logic [esc_pkg::STEP_BITS-1:0]   step,
    output logic                            fits,
    output logic [SECONDS_BITS-1:0]         diff
);

    logic [esc_pkg::STEP_BITS-1:0] wide;

    // difference is only used when the step fits
    always_comb
    begin
        wide = esc_pkg::STEP_BITS'(secs);
        fits = wide >= step;
        diff = SECONDS_BITS'(wide - step);
    end

endmodule

/* rtl/epoch_seconds_to_calendar_core.sv */
// epoch_seconds_to_calendar_core: seconds since 1970-01-01 to gregorian breakdown
// depends on esc_pkg and esc_div
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  command   | start / busy         | epoch_seconds
//  result    | done (1-cycle pulse) | cal_year cal_month cal_day cal_hour
//            |                      | cal_minute cal_second week_day
//
// one transaction at a time, taken at an edge with start high and busy low.
// busy stays high through each subtract step, the exit step of each loop and the final step.
// done pulses in the cycle after the final step, with busy already low, so the next start
// is taken then. at 36 bits at most 5 spans of 400 years are removed; each extra
// input bit can double the span loop.
// rst_n clears the sequencer only; the datapath loads on acceptance.
// the receiver cannot stall: each result is valid while done is high and holds until the next start is taken.

module epoch_seconds_to_calendar_core #(
    parameter int unsigned SECONDS_BITS = 36
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SECONDS_BITS-1:0] epoch_seconds,
    output logic                    done,
    output logic [12:0]             cal_year,
    output logic [3:0]              cal_month,
    output logic [4:0]              cal_day,
    output logic [4:0]              cal_hour,
    output logic [5:0]              cal_minute,
    output logic [5:0]              cal_second,
    output logic [2:0]              week_day
);

    // sequencer
    esc_pkg::state_t                 state_reg, state_next;
    logic [esc_pkg::PC_BITS-1:0]     pc_reg,    pc_next;
    logic                            done_reg,  done_next;
    esc_pkg::uword_t                 uw;
    logic                            running;
    logic                            accept;
    logic                            jump;

    // subtract unit hookup
    logic [esc_pkg::STEP_BITS-1:0]   step_len;
    logic                            fits;
    logic [SECONDS_BITS-1:0]         sub_diff;

    // calendar datapath
    logic [SECONDS_BITS-1:0]         secs_reg;      // seconds left to place
    logic [esc_pkg::YEAR_BITS-1:0]   year_reg;
    logic [esc_pkg::YCYC_BITS-1:0]   ycyc_reg;
    logic [3:0]                      month_reg;
    logic [4:0]                      day_reg;
    logic [4:0]                      hour_reg;
    logic [5:0]                      min_reg;
    logic [2:0]                      wday_reg;

    logic                            leap;
    logic [4:0]                      mdays;
    logic [1:0]                      wday_inc;
    logic [3:0]                      wday_sum;
    logic [2:0]                      wday_step;

    assign uw      = esc_pkg::ucode(pc_reg);
    assign running = (state_reg == esc_pkg::ST_RUN);
    assign accept  = start && (state_reg == esc_pkg::ST_IDLE);

    assign leap     = esc_pkg::is_leap(ycyc_reg);
    assign mdays    = esc_pkg::month_len(month_reg, leap);
    assign step_len = esc_pkg::step_secs(uw.op, leap, mdays);

    // weekday moves by the step length mod 7; a 400-year span is whole weeks
    always_comb
    begin
        case (uw.op)
            esc_pkg::OP_YEAR:  wday_inc = leap ? 2'd2 : 2'd1;
            esc_pkg::OP_MONTH: wday_inc = 2'(mdays - 5'd28);
            esc_pkg::OP_DAY:   wday_inc = 2'd1;
            default:           wday_inc = 2'd0;
        endcase
    end

    assign wday_sum  = {1'b0, wday_reg} + {2'b00, wday_inc};
    assign wday_step = (wday_sum >= 4'd7) ? 3'(wday_sum - 4'd7) : wday_sum[2:0];

    // jump condition of the current step
    always_comb
    begin
        unique case (uw.cond)
            esc_pkg::CN_FITS:       jump = fits;
            esc_pkg::CN_MONTH_FITS: jump = fits && (month_reg != esc_pkg::MONTH_LAST);
            default:                jump = 1'b0;
        endcase
    end

    // next state and step counter
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            esc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = esc_pkg::ST_RUN;
                    pc_next    = esc_pkg::PC_START;
                end
            end
            esc_pkg::ST_RUN:
            begin
                pc_next = jump ? uw.target : pc_reg + 1'b1;
                if (uw.op == esc_pkg::OP_DONE)
                begin
                    state_next = esc_pkg::ST_IDLE;
                    pc_next    = esc_pkg::PC_START;
                    done_next  = 1'b1;
                end
            end
            default:
                state_next = esc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esc_pkg::ST_IDLE;
            pc_reg    <= esc_pkg::PC_START;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            done_reg  <= done_next;
        end
    end

    // datapath: load on acceptance, then one unit removed per taken step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            secs_reg  <= epoch_seconds;
            year_reg  <= esc_pkg::YEAR_BASE;
            ycyc_reg  <= esc_pkg::YCYC_BASE;
            month_reg <= 4'd0;
            day_reg   <= 5'd0;
            hour_reg  <= 5'd0;
            min_reg   <= 6'd0;
            wday_reg  <= esc_pkg::WDAY_BASE;
        end
        else if (running && jump)
        begin
            secs_reg <= sub_diff;
            wday_reg <= wday_step;
            case (uw.op)
                esc_pkg::OP_SPAN:
                    year_reg <= year_reg + esc_pkg::YEARS_PER_400;
                esc_pkg::OP_YEAR:
                begin
                    year_reg <= year_reg + 1'b1;
                    ycyc_reg <= (ycyc_reg == esc_pkg::YCYC_LAST) ? '0
                                                                 : ycyc_reg + 1'b1;
                end
                esc_pkg::OP_MONTH:
                    month_reg <= month_reg + 1'b1;
                esc_pkg::OP_DAY:
                    day_reg <= day_reg + 1'b1;
                esc_pkg::OP_HOUR:
                    hour_reg <= hour_reg + 1'b1;
                esc_pkg::OP_MIN:
                    min_reg <= min_reg + 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    esc_div #(
        .SECONDS_BITS (SECONDS_BITS)
    ) u_div (
        .secs (secs_reg),
        .step (step_len),
        .fits (fits),
        .diff (sub_diff)
    );

    assign busy       = running;
    assign done       = done_reg;
    assign cal_year   = year_reg;
    assign cal_month  = month_reg + 4'd1;
    assign cal_day    = day_reg + 5'd1;
    assign cal_hour   = hour_reg;
    assign cal_minute = min_reg;
    // after the minute loop fewer than 60 seconds are left
    assign cal_second = secs_reg[5:0];
    assign week_day   = wday_reg;

endmodule
